[src/aht_pkg.sv]
// Shared types and constants for the averaging hysteresis thermostat.
package aht_pkg;

	// Field widths fixed by the item format
	localparam int SAMPLE_W = 14;
	localparam int RAW_W    = 12;
	localparam int SP_W     = 14;
	localparam int DIFF_W   = 12;
	localparam int CORR_W   = 11;
	localparam int MS_W     = 32;
	localparam int FAIL_W   = 8;
	localparam int ACT_W    = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFF       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CORRECTION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEC_INT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CYC_INT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_DLY   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIM   = 3'd6;

	// Register reset values
	localparam logic signed [SP_W-1:0]   SETPOINT_RST = 14'sd11;
	localparam logic [DIFF_W-1:0]        DIFF_RST     = 12'd7;
	localparam logic signed [CORR_W-1:0] CORR_RST     = -11'sd10;
	localparam logic [MS_W-1:0]          DEC_INT_RST  = 32'd10000;
	localparam logic [MS_W-1:0]          CYC_INT_RST  = 32'd300000;
	localparam logic [MS_W-1:0]          INIT_DLY_RST = 32'd30000;
	localparam logic [FAIL_W-1:0]        FAIL_LIM_RST = 8'd4;
	localparam logic [MS_W-1:0]          LAST_ON_RST  = INIT_DLY_RST - CYC_INT_RST;
	localparam logic [FAIL_W-1:0]        FAIL_MAX     = 8'd255;

	// Result action codes
	typedef enum logic [ACT_W-1:0] {
		ACT_NONE        = 4'd0,
		ACT_IN_BAND     = 4'd1,
		ACT_TURNED_ON   = 4'd2,
		ACT_HELD_ON     = 4'd3,
		ACT_CYCLE_WAIT  = 4'd4,
		ACT_TURNED_OFF  = 4'd5,
		ACT_HELD_OFF    = 4'd6,
		ACT_FAIL_COUNT  = 4'd7,
		ACT_FAIL_OFF    = 4'd8
	} action_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_UPDATE,
		ST_MUL,
		ST_DECIDE,
		ST_DIV,
		ST_OUT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic update;
		logic mul;
		logic decide;
		logic div_step;
		logic out_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_last;
	} stat_t;

endpackage

[src/aht_ram.sv]
// Generic single write port RAM with registered read.
module aht_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 60
) (
	input  logic                                            clk,
	input  logic                                            we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
	input  logic [WIDTH-1:0]                                wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
	output logic [WIDTH-1:0]                                rdata_q
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

[src/aht_ctrl.sv]
// Sequencing state machine for one reading: fetch, update, multiply, decide, divide, output.
module aht_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output aht_pkg::cmd_t   cmd,
	input  aht_pkg::stat_t  stat
);
	aht_pkg::state_t state_q, state_nxt;
	logic            out_valid_q;
	logic            out_free;

	// Result register can take a new request when empty or being drained
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aht_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			aht_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = aht_pkg::ST_FETCH;
			end
			aht_pkg::ST_FETCH:  state_nxt = aht_pkg::ST_UPDATE;
			aht_pkg::ST_UPDATE: state_nxt = aht_pkg::ST_MUL;
			aht_pkg::ST_MUL:    state_nxt = aht_pkg::ST_DECIDE;
			aht_pkg::ST_DECIDE: state_nxt = aht_pkg::ST_DIV;
			aht_pkg::ST_DIV: begin
				if (stat.div_last) state_nxt = aht_pkg::ST_OUT;
			end
			aht_pkg::ST_OUT: begin
				if (out_free) state_nxt = aht_pkg::ST_IDLE;
			end
			default: state_nxt = aht_pkg::ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			aht_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			aht_pkg::ST_FETCH:  ;
			aht_pkg::ST_UPDATE: cmd.update   = 1'b1;
			aht_pkg::ST_MUL:    cmd.mul      = 1'b1;
			aht_pkg::ST_DECIDE: cmd.decide   = 1'b1;
			aht_pkg::ST_DIV:    cmd.div_step = 1'b1;
			aht_pkg::ST_OUT:    cmd.out_load = out_free;
			default: ;
		endcase
	end

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

[src/aht_dp.sv]
// Datapath: config registers, sample window, running sum, thresholds, relay logic, mean divider.
module aht_dp #(
	parameter int WINDOW = 60
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [aht_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [aht_pkg::CFG_DAT_W-1:0]        cfg_data,
	input  logic [aht_pkg::RAW_W-1:0]            raw_temp,
	input  logic                                 read_ok,
	input  logic [aht_pkg::MS_W-1:0]             now_ms,
	input  aht_pkg::cmd_t                        cmd,
	output aht_pkg::stat_t                       stat,
	output logic                                 heat_on,
	output logic signed [aht_pkg::SAMPLE_W-1:0]  mean_temp,
	output logic [aht_pkg::ACT_W-1:0]            action,
	output logic [aht_pkg::MS_W-1:0]             wait_left_ms
);
	localparam int SW     = aht_pkg::SAMPLE_W;
	localparam int MW     = aht_pkg::MS_W;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W  = SW + CNT_W;
	localparam int PROD_W = SUM_W + 2;
	localparam int DC_W   = $clog2(SUM_W);

	// Configuration registers
	logic signed [aht_pkg::SP_W-1:0]   setpoint_q;
	logic [aht_pkg::DIFF_W-1:0]        diff_q;
	logic signed [aht_pkg::CORR_W-1:0] corr_q;
	logic [MW-1:0]                     dec_int_q;
	logic [MW-1:0]                     cyc_int_q;
	logic [MW-1:0]                     init_dly_q;
	logic [aht_pkg::FAIL_W-1:0]        fail_lim_q;

	// Captured request
	logic [aht_pkg::RAW_W-1:0] raw_q;
	logic                      ok_q;
	logic [MW-1:0]             now_q;

	// Window state
	logic [SLOT_W-1:0]        slot_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [aht_pkg::FAIL_W-1:0] fail_q;
	logic [SW-1:0]            old_sample;
	logic signed [SW-1:0]     sample;
	logic                     full;
	logic signed [SUM_W-1:0]  sum_evict;
	logic signed [SUM_W-1:0]  sum_add;

	// Threshold stage
	logic signed [PROD_W-1:0] hi_q, lo_q;
	logic signed [PROD_W-1:0] thr_hi, thr_lo, cnt_ext, sum_ext;
	logic                     due_q;
	logic [MW-1:0]            since_q;

	// Decision state
	logic                     relay_q;
	logic [MW-1:0]            last_dec_q;
	logic [MW-1:0]            last_on_q;
	aht_pkg::action_t         act_q;
	logic [MW-1:0]            wait_q;

	// Divider
	logic [SUM_W-1:0]         quo_q;
	logic [CNT_W-1:0]         rem_q;
	logic                     neg_q;
	logic [DC_W-1:0]          div_cnt_q;
	logic [CNT_W:0]           trial;
	logic [CNT_W:0]           divisor;
	logic [SW-1:0]            quo_lo;

	// Config writes; timing writes re-arm the turn-on reference in the decision block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= aht_pkg::SETPOINT_RST;
			diff_q     <= aht_pkg::DIFF_RST;
			corr_q     <= aht_pkg::CORR_RST;
			dec_int_q  <= aht_pkg::DEC_INT_RST;
			cyc_int_q  <= aht_pkg::CYC_INT_RST;
			init_dly_q <= aht_pkg::INIT_DLY_RST;
			fail_lim_q <= aht_pkg::FAIL_LIM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aht_pkg::CFG_SETPOINT:   setpoint_q <= cfg_data[aht_pkg::SP_W-1:0];
				aht_pkg::CFG_DIFF:       diff_q     <= cfg_data[aht_pkg::DIFF_W-1:0];
				aht_pkg::CFG_CORRECTION: corr_q     <= cfg_data[aht_pkg::CORR_W-1:0];
				aht_pkg::CFG_DEC_INT:    dec_int_q  <= cfg_data;
				aht_pkg::CFG_CYC_INT:    cyc_int_q  <= cfg_data;
				aht_pkg::CFG_INIT_DLY:   init_dly_q <= cfg_data;
				aht_pkg::CFG_FAIL_LIM:   fail_lim_q <= cfg_data[aht_pkg::FAIL_W-1:0];
				default: ;
			endcase
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			raw_q <= raw_temp;
			ok_q  <= read_ok;
			now_q <= now_ms;
		end
	end

	// Corrected sample
	assign sample = $signed({2'b00, raw_q}) + $signed({{(SW - aht_pkg::CORR_W){corr_q[aht_pkg::CORR_W-1]}}, corr_q});
	assign full   = (cnt_q == CNT_W'(WINDOW));

	aht_ram #(
		.WIDTH(SW),
		.DEPTH(WINDOW)
	) u_window (
		.clk     (clk),
		.we      (cmd.update && ok_q),
		.waddr   (slot_q),
		.wdata   (sample),
		.raddr   (slot_q),
		.rdata_q (old_sample)
	);

	// Running sum: drop the oldest sample once the window is full
	assign sum_evict = full ? $signed({{(SUM_W - SW){old_sample[SW-1]}}, old_sample}) : '0;
	assign sum_add   = $signed({{(SUM_W - SW){sample[SW-1]}}, sample});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			cnt_q  <= '0;
			sum_q  <= '0;
			fail_q <= '0;
		end else if (cmd.update) begin
			if (ok_q) begin
				sum_q  <= sum_q - sum_evict + sum_add;
				slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
				if (!full) cnt_q <= cnt_q + 1'b1;
				fail_q <= '0;
			end else if (fail_q != aht_pkg::FAIL_MAX) begin
				fail_q <= fail_q + 1'b1;
			end
		end
	end

	// Thresholds scaled by count, and elapsed times
	assign thr_lo  = $signed({{(PROD_W - aht_pkg::SP_W){setpoint_q[aht_pkg::SP_W-1]}}, setpoint_q});
	assign thr_hi  = thr_lo + $signed({{(PROD_W - aht_pkg::DIFF_W){1'b0}}, diff_q});
	assign cnt_ext = $signed({{(PROD_W - CNT_W){1'b0}}, cnt_q});
	assign sum_ext = $signed({{(PROD_W - SUM_W){sum_q[SUM_W-1]}}, sum_q});

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			hi_q    <= thr_hi * cnt_ext;
			lo_q    <= thr_lo * cnt_ext;
			due_q   <= (now_q - last_dec_q) >= dec_int_q;
			since_q <= now_q - last_on_q;
		end
	end

	// Relay decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q    <= 1'b0;
			last_dec_q <= '0;
			last_on_q  <= aht_pkg::LAST_ON_RST;
			act_q      <= aht_pkg::ACT_NONE;
			wait_q     <= '0;
		end else if (cfg_we && cfg_index == aht_pkg::CFG_CYC_INT) begin
			last_on_q <= init_dly_q - cfg_data;
		end else if (cfg_we && cfg_index == aht_pkg::CFG_INIT_DLY) begin
			last_on_q <= cfg_data - cyc_int_q;
		end else if (cmd.decide) begin
			act_q  <= aht_pkg::ACT_NONE;
			wait_q <= '0;
			if (ok_q) begin
				if (due_q) begin
					last_dec_q <= now_q;
					if (sum_ext > hi_q) begin
						if (relay_q) begin
							act_q <= aht_pkg::ACT_HELD_ON;
						end else if (since_q < cyc_int_q) begin
							act_q  <= aht_pkg::ACT_CYCLE_WAIT;
							wait_q <= cyc_int_q - since_q;
						end else begin
							act_q     <= aht_pkg::ACT_TURNED_ON;
							relay_q   <= 1'b1;
							last_on_q <= now_q;
						end
					end else if (sum_ext < lo_q) begin
						act_q   <= relay_q ? aht_pkg::ACT_TURNED_OFF : aht_pkg::ACT_HELD_OFF;
						relay_q <= 1'b0;
					end else begin
						act_q <= aht_pkg::ACT_IN_BAND;
					end
				end
			end else if (fail_q > fail_lim_q) begin
				act_q   <= aht_pkg::ACT_FAIL_OFF;
				relay_q <= 1'b0;
			end else begin
				act_q <= aht_pkg::ACT_FAIL_COUNT;
			end
		end
	end

	// Restoring divider: |sum| / count, one quotient bit per cycle
	assign divisor = {1'b0, cnt_q};
	assign trial   = {rem_q, quo_q[SUM_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			quo_q     <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
			rem_q     <= '0;
			neg_q     <= sum_q[SUM_W-1];
			div_cnt_q <= DC_W'(SUM_W - 1);
		end else if (cmd.div_step) begin
			if (trial >= divisor) begin
				rem_q <= CNT_W'(trial - divisor);
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	assign stat.div_last = (div_cnt_q == '0);
	assign quo_lo        = quo_q[SW-1:0];

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			heat_on      <= relay_q;
			action       <= act_q;
			wait_left_ms <= wait_q;
			if (cnt_q == '0) begin
				mean_temp <= '0;
			end else begin
				mean_temp <= neg_q ? -$signed(quo_lo) : $signed(quo_lo);
			end
		end
	end

	// Checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(WINDOW)) else $error("sample count beyond window");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(WINDOW - 1)) else $error("write slot beyond window");
	a_turn_on: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(relay_q) |-> act_q == aht_pkg::ACT_TURNED_ON)
		else $error("relay rose without a turn-on decision");
	a_fail_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && ok_q) |=> fail_q == '0) else $error("good read left fail count");
	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> sum_q == '0) else $error("empty window with nonzero sum");

endmodule

[src/averaging_hysteresis_thermostat_core.sv]
// Top level of the averaging hysteresis thermostat.
// Each request is one sensor reading; a good read is corrected and enters a WINDOW-deep
// window whose running sum drives an on/off relay decision with hysteresis, a minimum
// on-to-on cycle time and an initial delay, while failed reads are counted and can force
// the relay off. One result follows every request. The mean comes from a restoring divider
// that produces one quotient bit per cycle over the width of the window sum, after the
// window memory read, the update and the multiply and decide steps. The result sits in
// an output register, so a held result does not block the next request from being taken;
// that request then waits in its last step until the held result drains.
// The user must write configuration only while no request is in flight; the block
// itself does not enforce this.
module averaging_hysteresis_thermostat_core #(
	parameter int WINDOW = 60
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [aht_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [aht_pkg::CFG_DAT_W-1:0]        cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [aht_pkg::RAW_W-1:0]            raw_temp,
	input  logic                                 read_ok,
	input  logic [aht_pkg::MS_W-1:0]             now_ms,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 heat_on,
	output logic signed [aht_pkg::SAMPLE_W-1:0]  mean_temp,
	output logic [aht_pkg::ACT_W-1:0]            action,
	output logic [aht_pkg::MS_W-1:0]             wait_left_ms
);
	aht_pkg::cmd_t  cmd;
	aht_pkg::stat_t stat;

	aht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	aht_dp #(
		.WINDOW(WINDOW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.raw_temp     (raw_temp),
		.read_ok      (read_ok),
		.now_ms       (now_ms),
		.cmd          (cmd),
		.stat         (stat),
		.heat_on      (heat_on),
		.mean_temp    (mean_temp),
		.action       (action),
		.wait_left_ms (wait_left_ms)
	);

endmodule
